[rtl/core/utf8d_pkg.sv]
// Shared types and constants for the UTF-8 to 16-bit code point decoder.
package utf8d_pkg;

  localparam logic [15:0] SPACE_CHAR = 16'h0020;

  // Number of bytes held between items
  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_ONE  = 2'd1;
  localparam logic [1:0] HELD_TWO  = 2'd2;

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;

  // Results of one input item: k spaces, then an optional main result,
  // then spaces up to a total of n.
  typedef struct packed {
    logic [1:0]  k;
    logic        main_valid;
    logic [15:0] main_cp;
    logic        main_inv;
    logic [1:0]  n;
    logic        last;
  } bundle_t;

endpackage

[rtl/core/utf8d_if.sv]
// Valid/ready channel interfaces for the byte input and code point output.
interface utf8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface utf8d_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_point;
  logic        invalid;
  logic        out_last;

  modport source (output valid, output code_point, output invalid, output out_last,
                  input ready);
  modport sink (input valid, input code_point, input invalid, input out_last,
                output ready);
endinterface

[rtl/core/utf8d_decode.sv]
// Sequence state and single-pass decode of one byte into a result bundle.
module utf8d_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output utf8d_pkg::bundle_t bundle
);
  import utf8d_pkg::*;

  logic [7:0] held_lead, held_lead_next;
  logic [7:0] held_cont, held_cont_next;
  logic [1:0] held_count, held_count_next;
  logic       three_byte_seq, three_byte_seq_next;
  logic       is_cont;
  logic       start;
  logic [1:0] flush;

  assign is_cont = (in_byte & CONT_MASK) == CONT_CODE;

  always_comb begin
    held_lead_next      = held_lead;
    held_cont_next      = held_cont;
    held_count_next     = held_count;
    three_byte_seq_next = three_byte_seq;
    bundle.k            = 2'd0;
    bundle.main_valid   = 1'b0;
    bundle.main_cp      = SPACE_CHAR;
    bundle.main_inv     = 1'b1;
    start               = 1'b0;

    case (held_count)
      HELD_ONE: begin
        if (is_cont) begin
          if (!three_byte_seq) begin
            bundle.main_valid = 1'b1;
            bundle.main_cp    = {5'd0, held_lead[4:0], in_byte[5:0]};
            bundle.main_inv   = 1'b0;
            held_count_next   = HELD_NONE;
          end else begin
            held_cont_next  = in_byte;
            held_count_next = HELD_TWO;
          end
        end else begin
          bundle.k = 2'd1;
          start    = 1'b1;
        end
      end
      HELD_TWO: begin
        if (is_cont) begin
          bundle.main_valid = 1'b1;
          bundle.main_cp    = {held_lead[3:0], held_cont[5:0], in_byte[5:0]};
          bundle.main_inv   = 1'b0;
          held_count_next   = HELD_NONE;
        end else begin
          // held lead and held continuation both go out as spaces
          bundle.k = 2'd2;
          start    = 1'b1;
        end
      end
      default: begin
        start = 1'b1;
      end
    endcase

    if (start) begin
      held_count_next = HELD_NONE;
      if (!in_byte[7]) begin
        bundle.main_valid = 1'b1;
        bundle.main_cp    = {8'd0, in_byte};
        bundle.main_inv   = 1'b0;
      end else if ((in_byte & LEAD2_MASK) == LEAD2_CODE) begin
        held_lead_next      = in_byte;
        held_count_next     = HELD_ONE;
        three_byte_seq_next = 1'b0;
      end else if ((in_byte & LEAD3_MASK) == LEAD3_CODE) begin
        held_lead_next      = in_byte;
        held_count_next     = HELD_ONE;
        three_byte_seq_next = 1'b1;
      end else begin
        bundle.main_valid = 1'b1;
      end
    end

    // flush whatever stays held on the last byte
    flush = in_last ? held_count_next : HELD_NONE;
    if (in_last) begin
      held_lead_next      = 8'd0;
      held_cont_next      = 8'd0;
      held_count_next     = HELD_NONE;
      three_byte_seq_next = 1'b0;
    end

    bundle.n    = bundle.k + {1'b0, bundle.main_valid} + flush;
    bundle.last = in_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_lead      <= 8'd0;
      held_cont      <= 8'd0;
      held_count     <= HELD_NONE;
      three_byte_seq <= 1'b0;
    end else if (accept) begin
      held_lead      <= held_lead_next;
      held_cont      <= held_cont_next;
      held_count     <= held_count_next;
      three_byte_seq <= three_byte_seq_next;
    end
  end

endmodule

[rtl/core/utf8d_emit.sv]
// Bundle register and output register: hand out one result per cycle while the output is not stalled.
module utf8d_emit (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  utf8d_pkg::bundle_t bundle,
  output logic               in_ready,
  utf8d_out_if.source        chars
);
  import utf8d_pkg::*;

  bundle_t     held;
  logic        held_valid;
  logic [1:0]  idx;
  logic        out_free;
  logic        advance;
  logic        done;
  logic        at_main;
  logic [15:0] sel_cp;
  logic        sel_inv;

  assign out_free = !chars.valid || chars.ready;
  assign advance  = held_valid && out_free;
  assign done     = advance && (idx == held.n - 2'd1);
  assign in_ready = !held_valid || done;

  assign at_main = held.main_valid && (idx == held.k);
  assign sel_cp  = at_main ? held.main_cp : SPACE_CHAR;
  assign sel_inv = at_main ? held.main_inv : 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      idx        <= 2'd0;
    end else begin
      if (accept && (bundle.n != 2'd0)) begin
        held_valid <= 1'b1;
        idx        <= 2'd0;
      end else if (done) begin
        held_valid <= 1'b0;
      end else if (advance) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chars.valid <= 1'b0;
    end else if (advance) begin
      chars.valid <= 1'b1;
    end else if (chars.ready) begin
      chars.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      chars.code_point <= sel_cp;
      chars.invalid    <= sel_inv;
      chars.out_last   <= held.last && (idx == held.n - 2'd1);
    end
  end

endmodule

[rtl/core/utf8_to_ucs2_decoder.sv]
// Top level of the UTF-8 to 16-bit code point decoder.
//   channel  dir  payload                          accepted when
//   bytes    in   in_byte[7:0], in_last            valid && ready
//   chars    out  code_point[15:0], invalid,       valid && ready
//                 out_last
// One byte is taken per cycle when each byte gives at most one result and the output does not stall.
// A byte that gives n results (up to three) holds the input until the single
// output register has drained all n, one result per cycle while not stalled.
// A byte's first result passes through the bundle register, then the output register.
// rst is synchronous; it drops held bytes and any results not yet taken.
// An output stall holds results; the input keeps taking bytes until the
// pending bundle cannot move into the output register.
module utf8_to_ucs2_decoder (
  input  logic        clk,
  input  logic        rst,
  utf8d_in_if.sink    bytes,
  utf8d_out_if.source chars
);
  import utf8d_pkg::*;

  bundle_t dec;
  logic    accept;
  logic    in_ready;

  assign bytes.ready = in_ready;
  assign accept      = bytes.valid && in_ready;

  utf8d_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (bytes.in_byte),
    .in_last (bytes.in_last),
    .bundle  (dec)
  );

  utf8d_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .bundle   (dec),
    .in_ready (in_ready),
    .chars    (chars)
  );

`ifndef SYNTHESIS
  // the main result must sit inside the result count
  a_main_in_range: assert property (@(posedge clk) disable iff (rst)
    accept && dec.main_valid |-> dec.k < dec.n)
    else $error("main result index beyond result count");

  // a substituted result is always a space
  a_invalid_space: assert property (@(posedge clk) disable iff (rst)
    chars.valid && chars.invalid |-> chars.code_point == SPACE_CHAR)
    else $error("invalid result is not a space");

  // with a bundle pending, input is ready only if the output register can move
  a_ready_needs_room: assert property (@(posedge clk) disable iff (rst)
    accept && (dec.n != 2'd0) |=> !bytes.ready || !chars.valid || chars.ready)
    else $error("input ready while pending results are blocked");
`endif

endmodule
